>>> design/fipd_pkg.sv
// ============================================================================
// Fuzzy incremental PD controller package
// Shared types, register indexes, sequencer states and saturation helpers.
// ============================================================================
package fipd_pkg;

    localparam int unsigned DataWidth   = 32;
    localparam int unsigned OpWidth     = 33;
    localparam int unsigned ProdWidth   = 66;
    localparam int unsigned DriveWidth  = 23;
    localparam int unsigned PeriodWidth = 16;
    localparam int unsigned IndexWidth  = 3;
    localparam int unsigned UnitWidth   = 18;
    localparam int unsigned ShiftWidth  = 50;

    localparam logic [DriveWidth-1:0]  DRIVE_MAX           = 23'd6553600;
    localparam logic [PeriodWidth-1:0] PERIOD_RESET        = 16'd655;
    localparam logic [DataWidth-1:0]   INV_PERIOD_RESET    = 32'd6553600;

    typedef enum logic [IndexWidth-1:0] {
        REG_ERROR_GAIN  = 3'd0,
        REG_CHANGE_GAIN = 3'd1,
        REG_OUTPUT_GAIN = 3'd2,
        REG_PERIOD      = 3'd3,
        REG_INV_PERIOD  = 3'd4
    } reg_index_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RATE  = 9'b000000010,
        ST_ERRM  = 9'b000000100,
        ST_CHGM  = 9'b000001000,
        ST_MEAN  = 9'b000010000,
        ST_OUTM  = 9'b000100000,
        ST_SCALE = 9'b001000000,
        ST_AREA  = 9'b010000000,
        ST_ACC   = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        OP_RATE   = 3'd0,
        OP_ERROR  = 3'd1,
        OP_CHANGE = 3'd2,
        OP_OUTPUT = 3'd3,
        OP_AREA   = 3'd4
    } mul_op_t;

    typedef struct packed {
        logic    in_ready;
        logic    mul_en;
        mul_op_t mul_op;
        logic    load_rate;
        logic    load_fe;
        logic    load_mean;
        logic    load_scaled;
        logic    finish;
    } ctrl_t;

    // Saturates a floor-shifted product to the signed 32-bit range.
    function automatic logic signed [DataWidth-1:0] sat_word(
        input logic signed [ShiftWidth-1:0] v
    );
        logic signed [DataWidth-1:0] r;
        begin
            if (v > 50'sd2147483647)
            begin
                r = 32'sh7FFFFFFF;
            end
            else if (v < -50'sd2147483648)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = v[DataWidth-1:0];
            end
            return r;
        end
    endfunction

    // Clamps a floor-shifted product to the range -1.0 to 1.0 as an 18-bit signed Q2.16 value.
    function automatic logic signed [UnitWidth-1:0] clamp_unit(
        input logic signed [ShiftWidth-1:0] v
    );
        logic signed [UnitWidth-1:0] r;
        begin
            if (v > 50'sd65536)
            begin
                r = 18'sd65536;
            end
            else if (v < -50'sd65536)
            begin
                r = -18'sd65536;
            end
            else
            begin
                r = v[UnitWidth-1:0];
            end
            return r;
        end
    endfunction

endpackage

>>> design/fipd_mul.sv
// ============================================================================
// Shared multiplier
// Signed 33 by 33 bit multiplier with a registered product.
// ============================================================================
module fipd_mul (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [fipd_pkg::OpWidth-1:0]   a,
    input  logic signed [fipd_pkg::OpWidth-1:0]   b,
    output logic signed [fipd_pkg::ProdWidth-1:0] prod
);

    logic signed [fipd_pkg::ProdWidth-1:0] prod_reg;
    logic signed [fipd_pkg::ProdWidth-1:0] prod_next;

    assign prod_next = a * b;
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

>>> design/fipd_ctrl.sv
// ============================================================================
// Controller sequencer
// Steps one sample through the shared multiplier and raises load strobes.
// ============================================================================
module fipd_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    clear_request,
    input  logic                    out_hold,
    output fipd_pkg::ctrl_t         ctrl
);

    fipd_pkg::state_t state_reg;
    fipd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fipd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        ctrl             = '0;
        ctrl.mul_op      = fipd_pkg::OP_RATE;
        case (state_reg)
            fipd_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = clear_request ? fipd_pkg::ST_ACC : fipd_pkg::ST_RATE;
                end
            end
            fipd_pkg::ST_RATE:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = fipd_pkg::OP_RATE;
                state_next  = fipd_pkg::ST_ERRM;
            end
            fipd_pkg::ST_ERRM:
            begin
                ctrl.load_rate = 1'b1;
                ctrl.mul_en    = 1'b1;
                ctrl.mul_op    = fipd_pkg::OP_ERROR;
                state_next     = fipd_pkg::ST_CHGM;
            end
            fipd_pkg::ST_CHGM:
            begin
                ctrl.load_fe = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.mul_op  = fipd_pkg::OP_CHANGE;
                state_next   = fipd_pkg::ST_MEAN;
            end
            fipd_pkg::ST_MEAN:
            begin
                ctrl.load_mean = 1'b1;
                state_next     = fipd_pkg::ST_OUTM;
            end
            fipd_pkg::ST_OUTM:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = fipd_pkg::OP_OUTPUT;
                state_next  = fipd_pkg::ST_SCALE;
            end
            fipd_pkg::ST_SCALE:
            begin
                ctrl.load_scaled = 1'b1;
                state_next       = fipd_pkg::ST_AREA;
            end
            fipd_pkg::ST_AREA:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = fipd_pkg::OP_AREA;
                state_next  = fipd_pkg::ST_ACC;
            end
            fipd_pkg::ST_ACC:
            begin
                if (!out_hold)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = fipd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fipd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/fuzzy_incremental_pd_controller.sv
// ============================================================================
// Fuzzy incremental PD controller
// A sample is accepted only in the idle state; its result is registered after
// the rate, error, change, mean, output, scale, area and accumulate states (only
// the accumulate state for a clear request), plus any output stall. The five
// products share one registered multiplier. Reset clears the controller state
// and loads the register defaults; a clear request clears only the state.
// ============================================================================
module fuzzy_incremental_pd_controller (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [fipd_pkg::IndexWidth-1:0]        cfg_index,
    input  logic [fipd_pkg::DataWidth-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [fipd_pkg::DataWidth-1:0]  setpoint,
    input  logic signed [fipd_pkg::DataWidth-1:0]  feedback,
    input  logic                                   clear_request,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [fipd_pkg::DriveWidth-1:0]        drive_value
);

    logic signed [fipd_pkg::DataWidth-1:0]   error_gain_reg;
    logic signed [fipd_pkg::DataWidth-1:0]   change_gain_reg;
    logic signed [fipd_pkg::DataWidth-1:0]   output_gain_reg;
    logic [fipd_pkg::PeriodWidth-1:0]        period_reg;
    logic [fipd_pkg::DataWidth-1:0]          inv_period_reg;

    logic signed [fipd_pkg::DataWidth-1:0]   prev_error_reg;
    logic signed [fipd_pkg::DataWidth-1:0]   prev_scaled_reg;
    logic [fipd_pkg::DriveWidth-1:0]         acc_reg;
    logic [fipd_pkg::DriveWidth-1:0]         acc_next;
    logic                                    out_valid_reg;

    logic signed [fipd_pkg::DataWidth-1:0]   error_reg;
    logic signed [fipd_pkg::DataWidth-1:0]   error_next;
    logic                                    clear_reg;
    logic signed [fipd_pkg::DataWidth-1:0]   rate_reg;
    logic signed [fipd_pkg::UnitWidth-1:0]   fe_reg;
    logic signed [fipd_pkg::UnitWidth-1:0]   mean_reg;
    logic signed [fipd_pkg::UnitWidth-1:0]   mean_next;
    logic signed [fipd_pkg::DataWidth-1:0]   scaled_reg;

    fipd_pkg::ctrl_t                         ctrl;
    logic                                    in_xfer;
    logic                                    out_hold;
    logic signed [fipd_pkg::OpWidth-1:0]     mul_a;
    logic signed [fipd_pkg::OpWidth-1:0]     mul_b;
    logic signed [fipd_pkg::ProdWidth-1:0]   prod;
    logic signed [fipd_pkg::ShiftWidth-1:0]  prod_q16;
    logic signed [fipd_pkg::OpWidth-1:0]     diff_in;
    logic signed [fipd_pkg::UnitWidth:0]     unit_sum;
    logic signed [fipd_pkg::UnitWidth-1:0]   fr_value;
    logic signed [fipd_pkg::DataWidth+1:0]   delta;
    logic signed [fipd_pkg::DataWidth+2:0]   acc_sum;

    assign in_ready    = ctrl.in_ready;
    assign in_xfer     = in_valid && ctrl.in_ready;
    assign out_hold    = out_valid_reg && !out_ready;
    assign out_valid   = out_valid_reg;
    assign drive_value = acc_reg;

    fipd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .clear_request (clear_request),
        .out_hold      (out_hold),
        .ctrl          (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_gain_reg  <= '0;
            change_gain_reg <= '0;
            output_gain_reg <= '0;
            period_reg      <= fipd_pkg::PERIOD_RESET;
            inv_period_reg  <= fipd_pkg::INV_PERIOD_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                fipd_pkg::REG_ERROR_GAIN:  error_gain_reg  <= cfg_data;
                fipd_pkg::REG_CHANGE_GAIN: change_gain_reg <= cfg_data;
                fipd_pkg::REG_OUTPUT_GAIN: output_gain_reg <= cfg_data;
                fipd_pkg::REG_PERIOD:      period_reg      <= cfg_data[fipd_pkg::PeriodWidth-1:0];
                fipd_pkg::REG_INV_PERIOD:  inv_period_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign diff_in = {setpoint[fipd_pkg::DataWidth-1], setpoint}
                   - {feedback[fipd_pkg::DataWidth-1], feedback};

    always_comb
    begin
        if (diff_in[fipd_pkg::OpWidth-1] != diff_in[fipd_pkg::DataWidth-1])
        begin
            error_next = diff_in[fipd_pkg::OpWidth-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            error_next = diff_in[fipd_pkg::DataWidth-1:0];
        end
    end

    always_comb
    begin
        case (ctrl.mul_op)
            fipd_pkg::OP_RATE:
            begin
                mul_a = {error_reg[fipd_pkg::DataWidth-1], error_reg}
                      - {prev_error_reg[fipd_pkg::DataWidth-1], prev_error_reg};
                mul_b = {1'b0, inv_period_reg};
            end
            fipd_pkg::OP_ERROR:
            begin
                mul_a = {error_reg[fipd_pkg::DataWidth-1], error_reg};
                mul_b = {error_gain_reg[fipd_pkg::DataWidth-1], error_gain_reg};
            end
            fipd_pkg::OP_CHANGE:
            begin
                mul_a = {rate_reg[fipd_pkg::DataWidth-1], rate_reg};
                mul_b = {change_gain_reg[fipd_pkg::DataWidth-1], change_gain_reg};
            end
            fipd_pkg::OP_OUTPUT:
            begin
                mul_a = {{(fipd_pkg::OpWidth-fipd_pkg::UnitWidth){mean_reg[fipd_pkg::UnitWidth-1]}},
                         mean_reg};
                mul_b = {output_gain_reg[fipd_pkg::DataWidth-1], output_gain_reg};
            end
            fipd_pkg::OP_AREA:
            begin
                mul_a = {scaled_reg[fipd_pkg::DataWidth-1], scaled_reg}
                      + {prev_scaled_reg[fipd_pkg::DataWidth-1], prev_scaled_reg};
                mul_b = {{(fipd_pkg::OpWidth-fipd_pkg::PeriodWidth){1'b0}}, period_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fipd_mul u_mul (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_q16  = prod[fipd_pkg::ProdWidth-1:16];
    assign fr_value  = fipd_pkg::clamp_unit(prod_q16);
    assign unit_sum  = {fe_reg[fipd_pkg::UnitWidth-1], fe_reg}
                     + {fr_value[fipd_pkg::UnitWidth-1], fr_value};
    assign mean_next = unit_sum[fipd_pkg::UnitWidth:1];

    // The area product stays below 2^48 in magnitude, so bits 50 to 17 hold the increment.
    assign delta   = prod[50:17];
    assign acc_sum = {{(fipd_pkg::DataWidth+3-fipd_pkg::DriveWidth){1'b0}}, acc_reg}
                   + {delta[fipd_pkg::DataWidth+1], delta};

    always_comb
    begin
        if (acc_sum[fipd_pkg::DataWidth+2])
        begin
            acc_next = '0;
        end
        else if (acc_sum > {{(fipd_pkg::DataWidth+3-fipd_pkg::DriveWidth){1'b0}},
                            fipd_pkg::DRIVE_MAX})
        begin
            acc_next = fipd_pkg::DRIVE_MAX;
        end
        else
        begin
            acc_next = acc_sum[fipd_pkg::DriveWidth-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            error_reg <= error_next;
            clear_reg <= clear_request;
        end
        if (ctrl.load_rate)
        begin
            rate_reg <= fipd_pkg::sat_word(prod_q16);
        end
        if (ctrl.load_fe)
        begin
            fe_reg <= fipd_pkg::clamp_unit(prod_q16);
        end
        if (ctrl.load_mean)
        begin
            mean_reg <= mean_next;
        end
        if (ctrl.load_scaled)
        begin
            scaled_reg <= fipd_pkg::sat_word(prod_q16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg  <= '0;
            prev_scaled_reg <= '0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.finish)
            begin
                out_valid_reg <= 1'b1;
                if (clear_reg)
                begin
                    prev_error_reg  <= '0;
                    prev_scaled_reg <= '0;
                    acc_reg         <= '0;
                end
                else
                begin
                    prev_error_reg  <= error_reg;
                    prev_scaled_reg <= scaled_reg;
                    acc_reg         <= acc_next;
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive_value <= fipd_pkg::DRIVE_MAX)
        else $error("drive value above full scale");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("sequencer ready right after a transfer");

    a_finish_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> (!out_valid_reg || out_ready))
        else $error("result finished over an untaken result");

    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> out_valid && in_ready)
        else $error("finished sample produced no result");

endmodule
